// File: hw/rtl/two_axis_step_cycle_sequencer_top_defines.svh
// Assertion macros for the two-axis step cycle sequencer.
// Included by any RTL file that carries concurrent checks; no other dependencies.
`ifndef TWO_AXIS_STEP_CYCLE_SEQUENCER_TOP_DEFINES_SVH
`define TWO_AXIS_STEP_CYCLE_SEQUENCER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define TSS_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tss check failed: same-cycle implication");
`define TSS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tss check failed: next-cycle implication");
`define TSS_ASSERT_NEVER(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("tss check failed: forbidden condition");
`else
`define TSS_ASSERT_IMPL(label, clk, rst, ante, cons)
`define TSS_ASSERT_NEXT(label, clk, rst, ante, cons)
`define TSS_ASSERT_NEVER(label, clk, rst, cond)
`endif

`endif

// File: hw/rtl/tss_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and reset values for the two-axis step cycle sequencer.
// No dependencies; tss_step, the top level and the bench refer to it by scoped names.
package tss_pkg;

   localparam int FEEDS_BEFORE_HOME = 2;

   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   typedef enum logic [1:0] {
      MODE_M1_TICK = 2'd0,
      MODE_M2_TICK = 2'd1,
      MODE_START   = 2'd2,
      MODE_MANUAL  = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      PH_IDLE     = 3'd0,
      PH_STROKING = 3'd1,
      PH_PAUSE    = 3'd2,
      PH_FEEDING  = 3'd3,
      PH_HOMING   = 3'd4,
      PH_MANUAL   = 3'd5
   } phase_type;

   // register index, taken from paddr[4:2]
   localparam logic [2:0] REG_M1_HALF_PERIOD       = 3'd0;
   localparam logic [2:0] REG_M1_TOGGLES_PER_STROKE = 3'd1;
   localparam logic [2:0] REG_STROKES_PER_CYCLE     = 3'd2;
   localparam logic [2:0] REG_M2_HALF_PERIOD        = 3'd3;
   localparam logic [2:0] REG_M2_TOGGLES_PER_FEED   = 3'd4;
   localparam logic [2:0] REG_REVERSAL_PAUSE_TICKS  = 3'd5;

   typedef struct packed {
      logic [15:0] m1_half_period;
      logic [15:0] m1_toggles_per_stroke;
      logic [7:0]  strokes_per_cycle;
      logic [15:0] m2_half_period;
      logic [7:0]  m2_toggles_per_feed;
      logic [15:0] reversal_pause_ticks;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      m1_half_period:        16'd4,
      m1_toggles_per_stroke: 16'd200,
      strokes_per_cycle:     8'd4,
      m2_half_period:        16'd4,
      m2_toggles_per_feed:   8'd200,
      reversal_pause_ticks:  16'd100
   };

   typedef struct packed {
      logic [1:0] mode;
      logic       manual_hold;
      logic       jog_motor1;
      logic       jog_motor2;
      logic       seek_home;
      logic       home_reached;
   } req_type;

   typedef struct packed {
      logic       m1_enable;
      logic       m1_step;
      logic       m1_dir;
      logic       m2_enable;
      logic       m2_step;
      logic [2:0] phase;
   } rsp_type;

   typedef struct packed {
      logic        armed;
      logic        stroking;
      logic        feeding;
      logic        homing;
      logic        in_manual;
      logic [15:0] m1_toggle_count;
      logic [15:0] m1_wait;
      logic [7:0]  strokes_left;
      logic [15:0] pause_left;
      logic [7:0]  m2_toggle_count;
      logic [15:0] m2_wait;
      logic [1:0]  feeds_done;
      logic        m1_en;
      logic        m1_step;
      logic        m1_dir;
      logic        m2_en;
      logic        m2_step;
   } state_type;

   localparam state_type STATE_RESET = '{
      armed:           1'b1,
      stroking:        1'b0,
      feeding:         1'b0,
      homing:          1'b0,
      in_manual:       1'b0,
      m1_toggle_count: 16'd0,
      m1_wait:         16'd0,
      strokes_left:    8'd4,
      pause_left:      16'd0,
      m2_toggle_count: 8'd0,
      m2_wait:         16'd0,
      feeds_done:      2'd0,
      m1_en:           1'b0,
      m1_step:         1'b0,
      m1_dir:          1'b1,
      m2_en:           1'b0,
      m2_step:         1'b0
   };

endpackage

// File: hw/rtl/tss_req_if.sv
`timescale 1ns / 1ps
// Event channel into the sequencer: valid/ready handshake plus one event word.
// Depends on nothing.
interface tss_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] mode;
   logic       manual_hold;
   logic       jog_motor1;
   logic       jog_motor2;
   logic       seek_home;
   logic       home_reached;

   modport source (output valid, mode, manual_hold, jog_motor1, jog_motor2, seek_home,
                   home_reached, input ready);
   modport sink   (input valid, mode, manual_hold, jog_motor1, jog_motor2, seek_home,
                   home_reached, output ready);
endinterface

// File: hw/rtl/tss_rsp_if.sv
`timescale 1ns / 1ps
// Result channel out of the sequencer: valid/ready handshake plus drive levels and phase.
// Depends on nothing.
interface tss_rsp_if;
   logic       valid;
   logic       ready;
   logic       m1_enable;
   logic       m1_step;
   logic       m1_dir;
   logic       m2_enable;
   logic       m2_step;
   logic [2:0] phase;

   modport source (output valid, m1_enable, m1_step, m1_dir, m2_enable, m2_step, phase,
                   input ready);
   modport sink   (input valid, m1_enable, m1_step, m1_dir, m2_enable, m2_step, phase,
                   output ready);
endinterface

// File: hw/rtl/tss_step.sv
`timescale 1ns / 1ps
// Next-state and result logic for one event word of the step cycle sequencer.
// Depends on tss_pkg.
module tss_step (
   input  tss_pkg::state_type cur_state,
   input  tss_pkg::cfg_type   cfg,
   input  tss_pkg::req_type   item,
   output tss_pkg::state_type nxt_state,
   output tss_pkg::rsp_type   result
);

   // reach home: stop motor two there, else take one more toggle
   function automatic tss_pkg::state_type home_step(tss_pkg::state_type s, logic at_home);
      tss_pkg::state_type r;
      r = s;
      if (at_home) begin
         r.homing     = 1'b0;
         r.m2_en      = 1'b0;
         r.m2_step    = 1'b0;
         r.feeds_done = 2'd0;
      end else begin
         r.homing  = 1'b1;
         r.m2_en   = 1'b1;
         r.m2_step = ~s.m2_step;
      end
      return r;
   endfunction

   tss_pkg::state_type s;
   tss_pkg::phase_type ph;

   always_comb begin
      s = cur_state;
      case (item.mode)
         tss_pkg::MODE_MANUAL: begin
            if (!s.in_manual) begin
               s.armed    = 1'b0;
               s.stroking = 1'b0;
               s.feeding  = 1'b0;
               if (s.homing) begin
                  s.feeds_done = 2'd0;
               end
               s.homing     = 1'b0;
               s.pause_left = 16'd0;
               s.m2_step    = 1'b0;
               s.m2_en      = 1'b0;
               s.m1_en      = 1'b0;
               s.m1_dir     = 1'b0;
               if (item.manual_hold) begin
                  s.armed = 1'b1;
               end else begin
                  s.in_manual = 1'b1;
               end
            end else if (item.manual_hold) begin
               s.in_manual = 1'b0;
               s.armed     = 1'b1;
               s.m1_en     = 1'b0;
               s.m1_step   = 1'b0;
               s.m2_en     = 1'b0;
               s.m2_step   = 1'b0;
            end
            // jog only while staying in manual
            if (s.in_manual && !item.manual_hold) begin
               if (item.jog_motor1) begin
                  s.m1_en   = 1'b1;
                  s.m1_step = ~s.m1_step;
               end else begin
                  s.m1_en   = 1'b0;
                  s.m1_step = 1'b0;
                  if (item.jog_motor2 || (item.seek_home && !item.home_reached)) begin
                     s.m2_en   = 1'b1;
                     s.m2_step = ~s.m2_step;
                  end else begin
                     s.m2_en   = 1'b0;
                     s.m2_step = 1'b0;
                  end
               end
            end
         end
         tss_pkg::MODE_M1_TICK: begin
            if (!s.in_manual && s.stroking && !s.homing) begin
               s.armed = 1'b0;
               if (s.pause_left != 16'd0) begin
                  s.pause_left = s.pause_left - 16'd1;
                  if (s.pause_left == 16'd0) begin
                     s.m1_en = 1'b1;
                  end
               end else begin
                  s.m1_en = 1'b1;
                  if (s.strokes_left != 8'd0) begin
                     if (s.m1_wait == 16'd0) begin
                        s.m1_step         = ~s.m1_step;
                        s.m1_toggle_count = s.m1_toggle_count + 16'd1;
                        s.m1_wait         = cfg.m1_half_period;
                     end else begin
                        s.m1_wait = s.m1_wait - 16'd1;
                     end
                     if (s.m1_toggle_count >= cfg.m1_toggles_per_stroke) begin
                        s.m1_toggle_count = 16'd0;
                        s.strokes_left    = s.strokes_left - 8'd1;
                        s.m1_step         = 1'b0;
                        s.m1_dir          = ~s.m1_dir;
                        s.pause_left      = cfg.reversal_pause_ticks;
                        s.m1_en           = (cfg.reversal_pause_ticks == 16'd0);
                     end
                  end else begin
                     s.m1_dir       = 1'b1;
                     s.m1_en        = 1'b0;
                     s.stroking     = 1'b0;
                     s.feeding      = 1'b1;
                     s.m2_wait      = 16'd0;
                     s.strokes_left = cfg.strokes_per_cycle;
                  end
               end
            end
         end
         tss_pkg::MODE_M2_TICK: begin
            if (!s.in_manual) begin
               if (s.homing) begin
                  s = home_step(s, item.home_reached);
               end else if (s.feeding) begin
                  s.m2_en = 1'b1;
                  if (s.m2_wait == 16'd0) begin
                     s.m2_step         = ~s.m2_step;
                     s.m2_toggle_count = s.m2_toggle_count + 8'd1;
                     s.m2_wait         = cfg.m2_half_period;
                  end else begin
                     s.m2_wait = s.m2_wait - 16'd1;
                  end
                  if (s.m2_toggle_count >= cfg.m2_toggles_per_feed) begin
                     s.m2_toggle_count = 8'd0;
                     s.feeding         = 1'b0;
                     s.m2_en           = 1'b0;
                     s.m2_step         = 1'b0;
                     s.armed           = 1'b1;
                     s.stroking        = 1'b1;
                     s.m1_wait         = 16'd0;
                     s.feeds_done      = s.feeds_done + 2'd1;
                     if (s.feeds_done == 2'(tss_pkg::FEEDS_BEFORE_HOME)) begin
                        s = home_step(s, item.home_reached);
                     end
                  end
               end
            end
         end
         tss_pkg::MODE_START: begin
            if (!s.in_manual && s.armed && !s.homing) begin
               s.stroking = 1'b1;
               s.m1_wait  = 16'd0;
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      if (s.in_manual) begin
         ph = tss_pkg::PH_MANUAL;
      end else if (s.homing) begin
         ph = tss_pkg::PH_HOMING;
      end else if (s.feeding) begin
         ph = tss_pkg::PH_FEEDING;
      end else if (s.stroking && (s.pause_left != 16'd0)) begin
         ph = tss_pkg::PH_PAUSE;
      end else if (s.stroking) begin
         ph = tss_pkg::PH_STROKING;
      end else begin
         ph = tss_pkg::PH_IDLE;
      end
   end

   assign nxt_state        = s;
   assign result.m1_enable = s.m1_en;
   assign result.m1_step   = s.m1_step;
   assign result.m1_dir    = s.m1_dir;
   assign result.m2_enable = s.m2_en;
   assign result.m2_step   = s.m2_step;
   assign result.phase     = ph;

endmodule

// File: hw/rtl/two_axis_step_cycle_sequencer_top.sv
`timescale 1ns / 1ps
// Top level of the two-axis step cycle sequencer: CSR block, state and result registers.
// Depends on tss_pkg, tss_req_if, tss_rsp_if, tss_step and the defines header.
//
//   channel  | direction | handshake           | word
//   ---------+-----------+---------------------+------------------------------------
//   req_ch   | in        | valid/ready         | mode, manual_hold, jogs, home level
//   rsp_ch   | out       | valid/ready         | drive enables/steps/dir, phase
//   csr_*    | in        | APB write, pready=1 | six config registers at 4*i
//
// Cycles: one event word per clock; its result is in the output register the next cycle.
// The whole step is one pass through tss_step, from the state register to the result register.
// Stalls: req_ch.ready drops only while a result is held and rsp_ch.ready is low.
// Reset: synchronous, active high; state, config and the output valid flag go to defaults.
`include "two_axis_step_cycle_sequencer_top_defines.svh"

module two_axis_step_cycle_sequencer_top (
   input  logic                            clock,
   input  logic                            reset,
   tss_req_if.sink                         req_ch,
   tss_rsp_if.source                       rsp_ch,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [tss_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [tss_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [tss_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                            csr_pready
);

   tss_pkg::state_type state_ff, state_in;
   tss_pkg::cfg_type   cfg_ff, cfg_in;
   tss_pkg::rsp_type   rsp_ff, rsp_in;
   logic               rsp_valid_ff, rsp_valid_in;
   tss_pkg::req_type   item;
   tss_pkg::state_type step_state;
   logic               req_accept;
   logic               csr_write;
   logic [2:0]         csr_index;

   // ---------------- configuration port ----------------
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = csr_paddr[4:2];

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_index)
            tss_pkg::REG_M1_HALF_PERIOD:        cfg_in.m1_half_period        = csr_pwdata[15:0];
            tss_pkg::REG_M1_TOGGLES_PER_STROKE: cfg_in.m1_toggles_per_stroke = csr_pwdata[15:0];
            tss_pkg::REG_STROKES_PER_CYCLE:     cfg_in.strokes_per_cycle     = csr_pwdata[7:0];
            tss_pkg::REG_M2_HALF_PERIOD:        cfg_in.m2_half_period        = csr_pwdata[15:0];
            tss_pkg::REG_M2_TOGGLES_PER_FEED:   cfg_in.m2_toggles_per_feed   = csr_pwdata[7:0];
            tss_pkg::REG_REVERSAL_PAUSE_TICKS:  cfg_in.reversal_pause_ticks  = csr_pwdata[15:0];
            default: begin
               // drop writes outside the register map
            end
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         tss_pkg::REG_M1_HALF_PERIOD:        csr_prdata = {16'd0, cfg_ff.m1_half_period};
         tss_pkg::REG_M1_TOGGLES_PER_STROKE: csr_prdata = {16'd0, cfg_ff.m1_toggles_per_stroke};
         tss_pkg::REG_STROKES_PER_CYCLE:     csr_prdata = {24'd0, cfg_ff.strokes_per_cycle};
         tss_pkg::REG_M2_HALF_PERIOD:        csr_prdata = {16'd0, cfg_ff.m2_half_period};
         tss_pkg::REG_M2_TOGGLES_PER_FEED:   csr_prdata = {24'd0, cfg_ff.m2_toggles_per_feed};
         tss_pkg::REG_REVERSAL_PAUSE_TICKS:  csr_prdata = {16'd0, cfg_ff.reversal_pause_ticks};
         default:                            csr_prdata = '0;
      endcase
   end

   // ---------------- event handshake ----------------
   // accept whenever the output register is empty or being drained this cycle
   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign req_accept   = req_ch.valid && req_ch.ready;

   assign item.mode         = req_ch.mode;
   assign item.manual_hold  = req_ch.manual_hold;
   assign item.jog_motor1   = req_ch.jog_motor1;
   assign item.jog_motor2   = req_ch.jog_motor2;
   assign item.seek_home    = req_ch.seek_home;
   assign item.home_reached = req_ch.home_reached;

   tss_step u_step (
      .cur_state (state_ff),
      .cfg       (cfg_ff),
      .item      (item),
      .nxt_state (step_state),
      .result    (rsp_in)
   );

   // advance the state only on an accepted word; hold it otherwise
   assign state_in = req_accept ? step_state : state_ff;

   always_comb begin
      if (req_accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tss_pkg::STATE_RESET;
         cfg_ff       <= tss_pkg::CFG_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cfg_ff       <= cfg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result payload loads with each accepted word and needs no reset
   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.m1_enable = rsp_ff.m1_enable;
   assign rsp_ch.m1_step   = rsp_ff.m1_step;
   assign rsp_ch.m1_dir    = rsp_ff.m1_dir;
   assign rsp_ch.m2_enable = rsp_ff.m2_enable;
   assign rsp_ch.m2_step   = rsp_ff.m2_step;
   assign rsp_ch.phase     = rsp_ff.phase;

   // ---------------- checks ----------------
   `TSS_ASSERT_NEXT(a_accept_gives_result, clock, reset, req_accept, rsp_valid_ff)
   `TSS_ASSERT_NEXT(a_state_holds_idle, clock, reset, !req_accept, $stable(state_ff))
   `TSS_ASSERT_IMPL(a_manual_phase, clock, reset, rsp_valid_ff && state_ff.in_manual,
                    rsp_ff.phase == tss_pkg::PH_MANUAL)
   `TSS_ASSERT_NEVER(a_home_feed_excl, clock, reset, state_ff.homing && state_ff.feeding)

endmodule

// File: tb/two_axis_step_cycle_sequencer_top_test.sv
`timescale 1ns / 1ps
// Self-checking bench for the two-axis step cycle sequencer: event words in, drive-level words out.
// Depends on tss_pkg, tss_req_if, tss_rsp_if and two_axis_step_cycle_sequencer_top.
module two_axis_step_cycle_sequencer_top_test;

   // Own copy of the register set and of the sequencer state.
   typedef struct packed {
      logic [15:0] m1_half;
      logic [15:0] m1_target;
      logic [7:0]  strokes;
      logic [15:0] m2_half;
      logic [7:0]  m2_target;
      logic [15:0] pause_len;
   } seq_cfg_type;

   typedef struct packed {
      logic        armed;
      logic        stroking;
      logic        feeding;
      logic        homing;
      logic        manual_on;
      logic [15:0] m1_count;
      logic [15:0] m1_wait;
      logic [7:0]  strokes_left;
      logic [15:0] pause_left;
      logic [7:0]  m2_count;
      logic [15:0] m2_wait;
      logic [1:0]  feeds;
      logic        m1_en;
      logic        m1_step;
      logic        m1_dir;
      logic        m2_en;
      logic        m2_step;
   } axis_state_type;

   typedef struct packed {
      tss_pkg::req_type ev;
      logic             typed;
      tss_pkg::rsp_type levels;
   } script_row_type;

   localparam seq_cfg_type CFG_AT_RESET = '{16'd4, 16'd200, 8'd4, 16'd4, 8'd200, 16'd100};
   localparam axis_state_type AXIS_AT_RESET = '{
      armed: 1'b1, strokes_left: 8'd4, m1_dir: 1'b1, default: '0
   };
   localparam int NUM_PHASES = 8;

   bit   clock;
   logic reset;
   logic        csr_psel, csr_penable, csr_pwrite;
   logic [tss_pkg::CSR_ADDR_W-1:0] csr_paddr;
   logic [tss_pkg::CSR_DATA_W-1:0] csr_pwdata, csr_prdata;
   logic        csr_pready;

   tss_req_if req_ch ();
   tss_rsp_if rsp_ch ();

   two_axis_step_cycle_sequencer_top dut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   seq_cfg_type      mirror_cfg = CFG_AT_RESET;
   axis_state_type   mirror = AXIS_AT_RESET;
   tss_pkg::rsp_type due_levels [$];
   int               mismatch_count = 0;
   bit               steady = 1'b0;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // One motor two step at homing: stop at the sensor, else toggle on.
   function automatic void home_feed_step(logic at_home);
      if (at_home) begin
         mirror.homing = 1'b0;
         mirror.m2_en = 1'b0;
         mirror.m2_step = 1'b0;
         mirror.feeds = 2'd0;
      end else begin
         mirror.homing = 1'b1;
         mirror.m2_en = 1'b1;
         mirror.m2_step = ~mirror.m2_step;
      end
   endfunction

   // Apply one event word to the mirrored state and return the drive levels it leaves.
   function automatic tss_pkg::rsp_type advance_sequencer(tss_pkg::req_type ev);
      tss_pkg::rsp_type lv;
      logic             jog_ok;
      jog_ok = 1'b1;
      if (ev.mode == tss_pkg::MODE_MANUAL) begin
         if (!mirror.manual_on) begin
            // entry stops every automatic activity
            mirror.armed = 1'b0;
            mirror.stroking = 1'b0;
            mirror.feeding = 1'b0;
            if (mirror.homing) mirror.feeds = 2'd0;
            mirror.homing = 1'b0;
            mirror.pause_left = '0;
            mirror.m2_step = 1'b0;
            mirror.m2_en = 1'b0;
            mirror.m1_en = 1'b0;
            mirror.m1_dir = 1'b0;
            if (ev.manual_hold) begin
               mirror.armed = 1'b1;
               jog_ok = 1'b0;
            end else begin
               mirror.manual_on = 1'b1;
            end
         end else if (ev.manual_hold) begin
            mirror.manual_on = 1'b0;
            mirror.armed = 1'b1;
            mirror.m1_en = 1'b0;
            mirror.m1_step = 1'b0;
            mirror.m2_en = 1'b0;
            mirror.m2_step = 1'b0;
            jog_ok = 1'b0;
         end
         if (jog_ok) begin
            if (ev.jog_motor1) begin
               mirror.m1_en = 1'b1;
               mirror.m1_step = ~mirror.m1_step;
            end else begin
               mirror.m1_en = 1'b0;
               mirror.m1_step = 1'b0;
               if (ev.jog_motor2 || (ev.seek_home && !ev.home_reached)) begin
                  mirror.m2_en = 1'b1;
                  mirror.m2_step = ~mirror.m2_step;
               end else begin
                  mirror.m2_en = 1'b0;
                  mirror.m2_step = 1'b0;
               end
            end
         end
      end else if (!mirror.manual_on) begin
         case (ev.mode)
            tss_pkg::MODE_M1_TICK: if (mirror.stroking && !mirror.homing) begin
               mirror.armed = 1'b0;
               if (mirror.pause_left != 0) begin
                  mirror.pause_left = mirror.pause_left - 16'd1;
                  if (mirror.pause_left == 0) mirror.m1_en = 1'b1;
               end else begin
                  mirror.m1_en = 1'b1;
                  if (mirror.strokes_left != 0) begin
                     if (mirror.m1_wait == 0) begin
                        mirror.m1_step = ~mirror.m1_step;
                        mirror.m1_count = mirror.m1_count + 16'd1;
                        mirror.m1_wait = mirror_cfg.m1_half;
                     end else begin
                        mirror.m1_wait = mirror.m1_wait - 16'd1;
                     end
                     // stroke done: reverse and start the pause
                     if (mirror.m1_count >= mirror_cfg.m1_target) begin
                        mirror.m1_count = '0;
                        mirror.strokes_left = mirror.strokes_left - 8'd1;
                        mirror.m1_step = 1'b0;
                        mirror.m1_en = 1'b0;
                        mirror.m1_dir = ~mirror.m1_dir;
                        mirror.pause_left = mirror_cfg.pause_len;
                        if (mirror.pause_left == 0) mirror.m1_en = 1'b1;
                     end
                  end else begin
                     mirror.m1_dir = 1'b1;
                     mirror.m1_en = 1'b0;
                     mirror.stroking = 1'b0;
                     mirror.feeding = 1'b1;
                     mirror.m2_wait = '0;
                     mirror.strokes_left = mirror_cfg.strokes;
                  end
               end
            end
            tss_pkg::MODE_M2_TICK: if (mirror.homing) begin
               home_feed_step(ev.home_reached);
            end else if (mirror.feeding) begin
               mirror.m2_en = 1'b1;
               if (mirror.m2_wait == 0) begin
                  mirror.m2_step = ~mirror.m2_step;
                  mirror.m2_count = mirror.m2_count + 8'd1;
                  mirror.m2_wait = mirror_cfg.m2_half;
               end else begin
                  mirror.m2_wait = mirror.m2_wait - 16'd1;
               end
               // feed done: re-arm strokes, maybe start homing
               if (mirror.m2_count >= mirror_cfg.m2_target) begin
                  mirror.m2_count = '0;
                  mirror.feeding = 1'b0;
                  mirror.m2_en = 1'b0;
                  mirror.m2_step = 1'b0;
                  mirror.armed = 1'b1;
                  mirror.stroking = 1'b1;
                  mirror.m1_wait = '0;
                  mirror.feeds = mirror.feeds + 2'd1;
                  if (mirror.feeds == 2'(tss_pkg::FEEDS_BEFORE_HOME)) begin
                     home_feed_step(ev.home_reached);
                  end
               end
            end
            default: if (mirror.armed && !mirror.homing) begin
               mirror.stroking = 1'b1;
               mirror.m1_wait = '0;
            end
         endcase
      end

      if (mirror.manual_on) lv.phase = tss_pkg::PH_MANUAL;
      else if (mirror.homing) lv.phase = tss_pkg::PH_HOMING;
      else if (mirror.feeding) lv.phase = tss_pkg::PH_FEEDING;
      else if (mirror.stroking && mirror.pause_left != 0) lv.phase = tss_pkg::PH_PAUSE;
      else if (mirror.stroking) lv.phase = tss_pkg::PH_STROKING;
      else lv.phase = tss_pkg::PH_IDLE;
      lv.m1_enable = mirror.m1_en;
      lv.m1_step = mirror.m1_step;
      lv.m1_dir = mirror.m1_dir;
      lv.m2_enable = mirror.m2_en;
      lv.m2_step = mirror.m2_step;
      return lv;
   endfunction

   // Idle length: mostly none or short, now and then long.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(5, 25);
   endfunction

   // Steer toward the event the current phase wants, with some noise mixed in.
   function automatic tss_pkg::req_type pick_event();
      tss_pkg::req_type ev;
      int               r;
      ev = tss_pkg::req_type'(7'($urandom_range(0, 127)));
      r = $urandom_range(0, 99);
      if (r < 6) return ev;
      if (mirror.manual_on) begin
         ev.mode = tss_pkg::MODE_MANUAL;
         ev.manual_hold = ($urandom_range(0, 7) == 0);
      end else if (mirror.homing || mirror.feeding) begin
         ev.mode = (r < 85) ? tss_pkg::MODE_M2_TICK :
                   (r < 95) ? tss_pkg::MODE_M1_TICK : tss_pkg::MODE_START;
         if (mirror.homing) ev.home_reached = ($urandom_range(0, 3) == 0);
      end else if (mirror.stroking) begin
         ev.mode = (r < 85) ? tss_pkg::MODE_M1_TICK :
                   (r < 93) ? tss_pkg::MODE_M2_TICK : tss_pkg::MODE_START;
      end else begin
         ev.mode = (r < 75) ? tss_pkg::MODE_START :
                   (r < 88) ? tss_pkg::MODE_M1_TICK : tss_pkg::MODE_M2_TICK;
      end
      return ev;
   endfunction

   // Present one word, hold it until accepted, record what it should produce.
   task automatic send_event(input tss_pkg::req_type ev, input logic typed,
                             input tss_pkg::rsp_type typed_levels, output bit moved);
      axis_state_type   was;
      tss_pkg::rsp_type lv;
      int               gap;
      req_ch.valid <= 1'b1;
      req_ch.mode <= ev.mode;
      req_ch.manual_hold <= ev.manual_hold;
      req_ch.jog_motor1 <= ev.jog_motor1;
      req_ch.jog_motor2 <= ev.jog_motor2;
      req_ch.seek_home <= ev.seek_home;
      req_ch.home_reached <= ev.home_reached;
      do @(posedge clock); while (!req_ch.ready);
      was = mirror;
      lv = advance_sequencer(ev);
      moved = (was != mirror);
      due_levels.push_back(typed ? typed_levels : lv);
      @(negedge clock);
      if ($urandom_range(0, 31) == 0) steady = ~steady;
      gap = steady ? 0 : pick_gap();
      if (gap != 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   // Drop valid and hold until every outstanding result word is back.
   task automatic pause_until_drained();
      req_ch.valid <= 1'b0;
      do @(negedge clock); while (due_levels.size() != 0);
   endtask

   // Write all six registers back to back over the APB port.
   task automatic write_cfg(input seq_cfg_type c);
      logic [2:0]  reg_slot [6];
      logic [31:0] word_val [6];
      reg_slot[0] = tss_pkg::REG_M1_HALF_PERIOD;
      reg_slot[1] = tss_pkg::REG_M1_TOGGLES_PER_STROKE;
      reg_slot[2] = tss_pkg::REG_STROKES_PER_CYCLE;
      reg_slot[3] = tss_pkg::REG_M2_HALF_PERIOD;
      reg_slot[4] = tss_pkg::REG_M2_TOGGLES_PER_FEED;
      reg_slot[5] = tss_pkg::REG_REVERSAL_PAUSE_TICKS;
      word_val[0] = 32'(c.m1_half);
      word_val[1] = 32'(c.m1_target);
      word_val[2] = 32'(c.strokes);
      word_val[3] = 32'(c.m2_half);
      word_val[4] = 32'(c.m2_target);
      word_val[5] = 32'(c.pause_len);
      for (int k = 0; k < 6; k++) begin
         csr_psel <= 1'b1;
         csr_penable <= 1'b0;
         csr_pwrite <= 1'b1;
         csr_paddr <= {reg_slot[k], 2'b00};
         csr_pwdata <= word_val[k];
         @(negedge clock);
         csr_penable <= 1'b1;
         do @(posedge clock); while (!csr_pready);
         @(negedge clock);
      end
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      mirror_cfg = c;
   endtask

   task automatic check_field(input string name, input logic [2:0] want, input logic [2:0] got);
      if (want !== got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatch_count++;
      end
   endtask

   // Result side: random stalls, with long stretches of steady ready.
   initial begin : result_stall
      int run_left;
      run_left = 0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(negedge clock);
         if (run_left > 0) begin
            run_left--;
         end else if (rsp_ch.ready) begin
            run_left = pick_gap();
            if (run_left > 0) begin
               rsp_ch.ready <= 1'b0;
               run_left--;
            end
         end else begin
            rsp_ch.ready <= 1'b1;
            run_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80) : $urandom_range(0, 4);
         end
      end
   end

   // Compare each accepted result word with the oldest expectation.
   always @(posedge clock) begin : check_results
      tss_pkg::rsp_type due;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (due_levels.size() == 0) begin
            $error("result word with no expectation waiting");
            mismatch_count++;
         end else begin
            due = due_levels.pop_front();
            check_field("m1_enable", 3'(due.m1_enable), 3'(rsp_ch.m1_enable));
            check_field("m1_step", 3'(due.m1_step), 3'(rsp_ch.m1_step));
            check_field("m1_dir", 3'(due.m1_dir), 3'(rsp_ch.m1_dir));
            check_field("m2_enable", 3'(due.m2_enable), 3'(rsp_ch.m2_enable));
            check_field("m2_step", 3'(due.m2_step), 3'(rsp_ch.m2_step));
            check_field("phase", due.phase, rsp_ch.phase);
         end
      end
   end

   // Hard stop, several times the slowest legal run.
   initial begin
      #2_000_000;
      $display("== FAIL ==");
      $finish;
   end

   initial begin : stimulus
      script_row_type script [23];
      seq_cfg_type    phase_cfg [NUM_PHASES];
      int             phase_budget [NUM_PHASES];
      int             counted;
      bit             moved;
      bit             mid_done;

      reset <= 1'b1;
      req_ch.valid <= 1'b0;
      req_ch.mode <= tss_pkg::MODE_M1_TICK;
      req_ch.manual_hold <= 1'b0;
      req_ch.jog_motor1 <= 1'b0;
      req_ch.jog_motor2 <= 1'b0;
      req_ch.seek_home <= 1'b0;
      req_ch.home_reached <= 1'b0;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= '0;
      csr_pwdata <= '0;

      // Directed words at reset settings; levels typed in where obvious.
      script = '{
         '{'{tss_pkg::MODE_M1_TICK, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0}, 1'b1,
           '{1'b0, 1'b0, 1'b1, 1'b0, 1'b0, tss_pkg::PH_IDLE}},
         '{'{tss_pkg::MODE_M2_TICK, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1}, 1'b1,
           '{1'b0, 1'b0, 1'b1, 1'b0, 1'b0, tss_pkg::PH_IDLE}},
         '{'{tss_pkg::MODE_START, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0}, 1'b1,
           '{1'b0, 1'b0, 1'b1, 1'b0, 1'b0, tss_pkg::PH_STROKING}},
         '{'{tss_pkg::MODE_M1_TICK, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0}, 1'b1,
           '{1'b1, 1'b1, 1'b1, 1'b0, 1'b0, tss_pkg::PH_STROKING}},
         '{'{tss_pkg::MODE_M1_TICK, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1}, 1'b0, '0},
         // start while not armed
         '{'{tss_pkg::MODE_START, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0}, 1'b0, '0},
         '{'{tss_pkg::MODE_M2_TICK, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0}, 1'b0, '0},
         // manual entry with jog, then the jog priority order
         '{'{tss_pkg::MODE_MANUAL, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0}, 1'b0, '0},
         '{'{tss_pkg::MODE_MANUAL, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0}, 1'b0, '0},
         '{'{tss_pkg::MODE_MANUAL, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1}, 1'b0, '0},
         '{'{tss_pkg::MODE_MANUAL, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0}, 1'b0, '0},
         '{'{tss_pkg::MODE_MANUAL, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1}, 1'b0, '0},
         '{'{tss_pkg::MODE_MANUAL, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0}, 1'b0, '0},
         // motor ticks and start presses are dropped in manual
         '{'{tss_pkg::MODE_M1_TICK, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0}, 1'b0, '0},
         '{'{tss_pkg::MODE_START, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0}, 1'b0, '0},
         '{'{tss_pkg::MODE_M2_TICK, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0}, 1'b0, '0},
         // leave manual, then start again
         '{'{tss_pkg::MODE_MANUAL, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0}, 1'b1,
           '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, tss_pkg::PH_IDLE}},
         '{'{tss_pkg::MODE_START, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0}, 1'b1,
           '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, tss_pkg::PH_STROKING}},
         '{'{tss_pkg::MODE_M1_TICK, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0}, 1'b0, '0},
         // manual tick with hold high: entry, then re-armed at once
         '{'{tss_pkg::MODE_MANUAL, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1}, 1'b0, '0},
         '{'{tss_pkg::MODE_START, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1}, 1'b0, '0},
         '{'{tss_pkg::MODE_MANUAL, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0}, 1'b0, '0},
         '{'{tss_pkg::MODE_MANUAL, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0}, 1'b0, '0}
      };

      // Settings per phase: minimal, small, all zero, random small, small, random small, extremes last.
      phase_cfg[0] = '{16'd0, 16'd1, 8'd1, 16'd0, 8'd1, 16'd0};
      phase_cfg[1] = '{16'd1, 16'd3, 8'd2, 16'd1, 8'd2, 16'd2};
      phase_cfg[2] = '{16'd0, 16'd0, 8'd0, 16'd0, 8'd0, 16'd0};
      phase_cfg[3] = '{16'($urandom_range(0, 3)), 16'($urandom_range(1, 8)),
                       8'($urandom_range(1, 3)), 16'($urandom_range(0, 3)),
                       8'($urandom_range(1, 6)), 16'($urandom_range(0, 5))};
      phase_cfg[4] = '{16'd2, 16'd4, 8'd3, 16'd0, 8'd3, 16'd1};
      phase_cfg[5] = '{16'($urandom_range(0, 2)), 16'($urandom_range(1, 5)),
                       8'($urandom_range(1, 2)), 16'($urandom_range(0, 2)),
                       8'($urandom_range(1, 4)), 16'($urandom_range(0, 3))};
      phase_cfg[6] = '{16'd0, 16'd1, 8'd1, 16'd0, 8'd255, 16'd0};
      phase_cfg[7] = '{16'hFFFF, 16'hFFFF, 8'hFF, 16'hFFFF, 8'hFF, 16'hFFFF};
      phase_budget = '{170, 180, 120, 200, 170, 200, 100, 60};

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (script[i]) send_event(script[i].ev, script[i].typed, script[i].levels, moved);

      for (int p = 0; p < NUM_PHASES; p++) begin
         // registers change only with nothing in flight
         pause_until_drained();
         write_cfg(phase_cfg[p]);
         counted = 0;
         mid_done = 1'b0;
         while (counted < phase_budget[p]) begin
            send_event(pick_event(), 1'b0, '0, moved);
            if (moved) counted++;
            if (!mid_done && counted >= phase_budget[p] / 2) begin
               pause_until_drained();
               mid_done = 1'b1;
            end
         end
      end

      pause_until_drained();
      repeat (4) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
